@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ sv/dtr_pkg.sv @@
// Shared constants, types and helpers for the debounced toggle relay saver.
`default_nettype none

package dtr_pkg;

    localparam int DEVICES = 2;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int MASK_W  = 2;
    localparam int LVL_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] SAVE_DELAY_RESET = 16'd2000;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register select taken from the address word bit.
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_SAVE_DELAY = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_RESTORE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Saturating increment of a tick counter.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/debounced_toggle_relay_saver_top.sv @@
// Debounced toggle relay controller with delayed, coalesced state saving.
//
// Input stream (s_*): each transfer is one item. s_tuser carries the item
// kind (tick, set relay, restore boot state); s_tdata carries the device
// index, requested state, human flag and raw switch levels.
// Result stream (m_*): exactly one result transfer per input item, in order,
// with relay states, save mask and values, timer-cancel mask and a change flag.
// APB port: debounce_ticks at byte address 0, save_delay_ticks at address 4.
//
// Each item passes through the input register, then the per-device compare and
// count logic feeding the result register, which drives m_tvalid and m_tdata.
// One item is accepted every cycle while results are taken; the
// sustained rate is set by the single result register, one item per cycle.
// When the receiver stalls, the result holds and the input register fills,
// after which s_tready drops until the result transfer completes.
// Reset clears both stages, sets relays, saved and dirty state to zero,
// switch history to all ones (pulled up) and the registers to 50 and 2000.
`default_nettype none

module debounced_toggle_relay_saver_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dtr_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [dtr_pkg::PDATA_W-1:0]       pwdata,
    output logic      [dtr_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: [0] device, [1] on, [2] human, [4:3] switch_levels, [7:5] zero
    input  wire logic [dtr_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: [1:0] op
    input  wire logic [dtr_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: [1:0] relay_mask, [3:2] save_mask, [5:4] save_values,
    //          [7:6] cancel_mask, [8] changed, [15:9] zero
    output logic      [dtr_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int D  = dtr_pkg::DEVICES;
    localparam int CW = dtr_pkg::CNT_W;
    localparam int MW = dtr_pkg::MASK_W;
    localparam int LW = dtr_pkg::LVL_W;

    // Configuration registers
    logic [dtr_pkg::CFG_W-1:0] debounce_reg;
    logic [dtr_pkg::CFG_W-1:0] save_delay_reg;
    logic                      cfg_write;

    // Input stage
    logic              in_valid_reg;
    dtr_pkg::op_t      in_op_reg;
    logic              in_device_reg;
    logic              in_on_reg;
    logic              in_human_reg;
    logic [LW-1:0]     in_levels_reg;

    // Block state
    logic [D-1:0]  relay_reg,    relay_next;
    logic [D-1:0]  saved_reg,    saved_next;
    logic [D-1:0]  dirty_reg,    dirty_next;
    logic [D-1:0]  raw_last_reg, raw_last_next;
    logic [D-1:0]  stable_reg,   stable_next;
    logic [CW-1:0] edge_cnt_reg  [D];
    logic [CW-1:0] edge_cnt_next [D];
    logic [CW-1:0] dirty_cnt_reg  [D];
    logic [CW-1:0] dirty_cnt_next [D];

    // Result stage
    logic          out_valid_reg;
    logic [MW-1:0] relay_mask_reg;
    logic [MW-1:0] save_mask_reg;
    logic [MW-1:0] save_values_reg;
    logic [MW-1:0] cancel_mask_reg;
    logic          changed_reg;

    logic          out_free;
    logic          advance;

    logic [D-1:0]      save_m;
    logic [D-1:0]      save_v;
    logic [D-1:0]      cancel_m;
    logic              changed;
    logic [D+LW-1:0]   levels_pad;
    logic [D+MW-1:0]   relay_pad;
    logic [D+MW-1:0]   save_m_pad;
    logic [D+MW-1:0]   save_v_pad;
    logic [D+MW-1:0]   cancel_pad;

    // ---------------------------------------------------------------
    // APB
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[2])
            dtr_pkg::REG_DEBOUNCE:   prdata = {{(dtr_pkg::PDATA_W-dtr_pkg::CFG_W){1'b0}},
                                               debounce_reg};
            dtr_pkg::REG_SAVE_DELAY: prdata = {{(dtr_pkg::PDATA_W-dtr_pkg::CFG_W){1'b0}},
                                               save_delay_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= dtr_pkg::DEBOUNCE_RESET;
            save_delay_reg <= dtr_pkg::SAVE_DELAY_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == dtr_pkg::REG_DEBOUNCE) begin
                debounce_reg <= pwdata[dtr_pkg::CFG_W-1:0];
            end else begin
                save_delay_reg <= pwdata[dtr_pkg::CFG_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= dtr_pkg::op_t'(s_tuser[1:0]);
            in_device_reg <= s_tdata[0];
            in_on_reg     <= s_tdata[1];
            in_human_reg  <= s_tdata[2];
            in_levels_reg <= s_tdata[4:3];
        end
    end

    // ---------------------------------------------------------------
    // Per-device debounce, relay and save logic
    // ---------------------------------------------------------------
    assign levels_pad = {{D{1'b0}}, in_levels_reg};

    always_comb begin
        relay_next    = relay_reg;
        saved_next    = saved_reg;
        dirty_next    = dirty_reg;
        raw_last_next = raw_last_reg;
        stable_next   = stable_reg;
        save_m        = '0;
        save_v        = '0;
        cancel_m      = '0;
        changed       = 1'b0;
        for (int i = 0; i < D; i++) begin
            edge_cnt_next[i]  = edge_cnt_reg[i];
            dirty_cnt_next[i] = dirty_cnt_reg[i];
        end

        case (in_op_reg)
            dtr_pkg::OP_TICK: begin
                for (int i = 0; i < D; i++) begin
                    edge_cnt_next[i]  = dtr_pkg::bump(edge_cnt_reg[i]);
                    dirty_cnt_next[i] = dtr_pkg::bump(dirty_cnt_reg[i]);
                    if (levels_pad[i] != raw_last_reg[i]) begin
                        // A level change restarts the debounce count.
                        raw_last_next[i] = levels_pad[i];
                        edge_cnt_next[i] = '0;
                    end else if (edge_cnt_next[i] >= debounce_reg &&
                                 levels_pad[i] != stable_reg[i]) begin
                        // Accepted switch edge toggles the relay as a human action.
                        stable_next[i]    = levels_pad[i];
                        cancel_m[i]       = 1'b1;
                        relay_next[i]     = !relay_reg[i];
                        dirty_next[i]     = 1'b1;
                        dirty_cnt_next[i] = '0;
                        changed           = 1'b1;
                    end
                    // Save check sees this tick's toggle, so a zero delay saves at once.
                    if (dirty_next[i] && dirty_cnt_next[i] >= save_delay_reg) begin
                        if (relay_next[i] != saved_reg[i]) begin
                            saved_next[i] = relay_next[i];
                            save_m[i]     = 1'b1;
                            save_v[i]     = relay_next[i];
                        end
                        dirty_next[i] = 1'b0;
                    end
                end
            end
            dtr_pkg::OP_SET: begin
                for (int i = 0; i < D; i++) begin
                    if (int'(in_device_reg) == i) begin
                        cancel_m[i] = in_human_reg;
                        if (relay_reg[i] != in_on_reg) begin
                            relay_next[i]     = in_on_reg;
                            dirty_next[i]     = 1'b1;
                            dirty_cnt_next[i] = '0;
                            changed           = 1'b1;
                        end
                    end
                end
            end
            dtr_pkg::OP_RESTORE: begin
                for (int i = 0; i < D; i++) begin
                    if (int'(in_device_reg) == i) begin
                        relay_next[i]    = in_on_reg;
                        saved_next[i]    = in_on_reg;
                        dirty_next[i]    = 1'b0;
                        raw_last_next[i] = levels_pad[i];
                        stable_next[i]   = levels_pad[i];
                        edge_cnt_next[i] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign relay_pad  = {{MW{1'b0}}, relay_next};
    assign save_m_pad = {{MW{1'b0}}, save_m};
    assign save_v_pad = {{MW{1'b0}}, save_v};
    assign cancel_pad = {{MW{1'b0}}, cancel_m};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg    <= '0;
            saved_reg    <= '0;
            dirty_reg    <= '0;
            raw_last_reg <= '1;
            stable_reg   <= '1;
            for (int i = 0; i < D; i++) begin
                edge_cnt_reg[i]  <= '0;
                dirty_cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            relay_reg    <= relay_next;
            saved_reg    <= saved_next;
            dirty_reg    <= dirty_next;
            raw_last_reg <= raw_last_next;
            stable_reg   <= stable_next;
            for (int i = 0; i < D; i++) begin
                edge_cnt_reg[i]  <= edge_cnt_next[i];
                dirty_cnt_reg[i] <= dirty_cnt_next[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            relay_mask_reg  <= relay_pad[MW-1:0];
            save_mask_reg   <= save_m_pad[MW-1:0];
            save_values_reg <= save_v_pad[MW-1:0];
            cancel_mask_reg <= cancel_pad[MW-1:0];
            changed_reg     <= changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dtr_pkg::M_TDATA_W-4*MW-1){1'b0}}, changed_reg, cancel_mask_reg,
                       save_values_reg, save_mask_reg, relay_mask_reg};

endmodule

`default_nettype wire

@@ sv/dtr_checker.sv @@
// Port-level checker for the debounced toggle relay saver, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module dtr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dtr_pkg::M_TDATA_W-1:0] m_tdata
);

    // A saved value can only be one where the save mask is set.
    `ASSERT_CLK(a_save_values_in_mask, aclk, aresetn, m_tvalid |-> ((m_tdata[5:4] & ~m_tdata[3:2]) == 2'b00))

    // Input backpressure only comes from a stalled result.
    `ASSERT_CLK(a_stall_from_output, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready))

    // Reset empties the result stage.
    `ASSERT_CLK_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_tvalid)

    // A stalled result transfer keeps its data.
    `ASSERT_CLK(a_stalled_result_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind debounced_toggle_relay_saver_top dtr_checker u_dtr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
